>>> hdl/u8d_pkg.sv
package u8d_pkg;

  localparam int unsigned CP_W   = 21;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned USED_W = 3;
  localparam int unsigned NUM_LANES = 3;

  localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;
  localparam logic [CP_W-1:0] MIN_CP_2       = 21'h000080;
  localparam logic [CP_W-1:0] MIN_CP_3       = 21'h000800;
  localparam logic [CP_W-1:0] MIN_CP_4       = 21'h010000;
  localparam logic [CP_W-1:0] MAX_CP         = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO        = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI        = 21'h00DFFF;

  // Sequence lengths, also the bytes_used codes
  localparam logic [USED_W-1:0] LEN_END = 3'd0;
  localparam logic [USED_W-1:0] LEN_1   = 3'd1;
  localparam logic [USED_W-1:0] LEN_2   = 3'd2;
  localparam logic [USED_W-1:0] LEN_3   = 3'd3;
  localparam logic [USED_W-1:0] LEN_4   = 3'd4;

  typedef struct packed {
    logic            ok;
    logic [CP_W-1:0] cp;
  } lane_res_t;

  function automatic logic is_cont(input logic [BYTE_W-1:0] b);
    return b[7:6] == 2'b10;
  endfunction

endpackage

>>> hdl/utf8_codepoint_decoder.sv
// UTF-8 decoder: one four-byte window in, one code point out per transaction.
// Path: the window is held in the input register, then the lane merge register
// registers the result together with done.
// Throughput: one transaction every cycle; busy is held low, since each window
// decodes in one pass through the lanes.
// Reset (rst, synchronous): clears the valid pipeline so no stale done appears.
// The receiver cannot stall; each result shows for exactly one cycle.
module utf8_codepoint_decoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [u8d_pkg::BYTE_W-1:0]    first_byte,
  input  logic [u8d_pkg::BYTE_W-1:0]    second_byte,
  input  logic [u8d_pkg::BYTE_W-1:0]    third_byte,
  input  logic [u8d_pkg::BYTE_W-1:0]    fourth_byte,
  output logic                          done,
  output logic [u8d_pkg::CP_W-1:0]      code_point,
  output logic [u8d_pkg::USED_W-1:0]    bytes_used,
  output logic                          replaced
);

  logic                       valid;
  logic [u8d_pkg::BYTE_W-1:0] b0;
  logic [u8d_pkg::BYTE_W-1:0] b1;
  logic [u8d_pkg::BYTE_W-1:0] b2;
  logic [u8d_pkg::BYTE_W-1:0] b3;

  u8d_pkg::lane_res_t lane_res [u8d_pkg::NUM_LANES];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= start && !busy;
    end
    b0 <= first_byte;
    b1 <= second_byte;
    b2 <= third_byte;
    b3 <= fourth_byte;
  end

  // One lane per multi-byte sequence length: two, three and four bytes
  for (genvar i = 0; i < u8d_pkg::NUM_LANES; i++) begin : g_lane
    u8d_lane u_lane (
      .seq_len (u8d_pkg::USED_W'(i + 2)),
      .b0      (b0),
      .b1      (b1),
      .b2      (b2),
      .b3      (b3),
      .res     (lane_res[i])
    );
  end

  u8d_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .valid      (valid),
    .b0         (b0),
    .lane_res   (lane_res),
    .done       (done),
    .code_point (code_point),
    .bytes_used (bytes_used),
    .replaced   (replaced)
  );

endmodule

>>> hdl/u8d_lane.sv
module u8d_lane (
  input  logic [u8d_pkg::USED_W-1:0] seq_len,
  input  logic [u8d_pkg::BYTE_W-1:0] b0,
  input  logic [u8d_pkg::BYTE_W-1:0] b1,
  input  logic [u8d_pkg::BYTE_W-1:0] b2,
  input  logic [u8d_pkg::BYTE_W-1:0] b3,
  output u8d_pkg::lane_res_t         res
);

  logic [u8d_pkg::CP_W-1:0] cp2;
  logic [u8d_pkg::CP_W-1:0] cp3;
  logic [u8d_pkg::CP_W-1:0] cp4;

  assign cp2 = {10'd0, b0[4:0], b1[5:0]};
  assign cp3 = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
  assign cp4 = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};

  always_comb begin
    res.ok = 1'b0;
    res.cp = cp2;
    unique case (seq_len)
      u8d_pkg::LEN_2: begin
        res.cp = cp2;
        res.ok = (b0[7:5] == 3'b110) && u8d_pkg::is_cont(b1) &&
                 (cp2 >= u8d_pkg::MIN_CP_2);
      end
      u8d_pkg::LEN_3: begin
        res.cp = cp3;
        res.ok = (b0[7:4] == 4'b1110) && u8d_pkg::is_cont(b1) &&
                 u8d_pkg::is_cont(b2) && (cp3 >= u8d_pkg::MIN_CP_3) &&
                 ((cp3 < u8d_pkg::SURR_LO) || (cp3 > u8d_pkg::SURR_HI));
      end
      u8d_pkg::LEN_4: begin
        res.cp = cp4;
        res.ok = (b0[7:3] == 5'b11110) && u8d_pkg::is_cont(b1) &&
                 u8d_pkg::is_cont(b2) && u8d_pkg::is_cont(b3) &&
                 (cp4 >= u8d_pkg::MIN_CP_4) && (cp4 <= u8d_pkg::MAX_CP);
      end
      default: begin
        res.ok = 1'b0;
        res.cp = cp2;
      end
    endcase
  end

endmodule

>>> hdl/u8d_merge.sv
module u8d_merge (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          valid,
  input  logic [u8d_pkg::BYTE_W-1:0]    b0,
  input  u8d_pkg::lane_res_t            lane_res [u8d_pkg::NUM_LANES],
  output logic                          done,
  output logic [u8d_pkg::CP_W-1:0]      code_point,
  output logic [u8d_pkg::USED_W-1:0]    bytes_used,
  output logic                          replaced
);

  logic [u8d_pkg::CP_W-1:0]   code_point_next;
  logic [u8d_pkg::USED_W-1:0] bytes_used_next;
  logic                       replaced_next;

  // At most one lane can accept a given lead byte, so order only matters for end/ASCII
  always_comb begin
    code_point_next = u8d_pkg::REPLACEMENT_CP;
    bytes_used_next = u8d_pkg::LEN_1;
    replaced_next   = 1'b1;
    priority if (b0 == '0) begin
      code_point_next = '0;
      bytes_used_next = u8d_pkg::LEN_END;
      replaced_next   = 1'b0;
    end else if (!b0[7]) begin
      code_point_next = {13'd0, b0};
      bytes_used_next = u8d_pkg::LEN_1;
      replaced_next   = 1'b0;
    end else if (lane_res[0].ok) begin
      code_point_next = lane_res[0].cp;
      bytes_used_next = u8d_pkg::LEN_2;
      replaced_next   = 1'b0;
    end else if (lane_res[1].ok) begin
      code_point_next = lane_res[1].cp;
      bytes_used_next = u8d_pkg::LEN_3;
      replaced_next   = 1'b0;
    end else if (lane_res[2].ok) begin
      code_point_next = lane_res[2].cp;
      bytes_used_next = u8d_pkg::LEN_4;
      replaced_next   = 1'b0;
    end else begin
      code_point_next = u8d_pkg::REPLACEMENT_CP;
      bytes_used_next = u8d_pkg::LEN_1;
      replaced_next   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid;
    end
    code_point <= code_point_next;
    bytes_used <= bytes_used_next;
    replaced   <= replaced_next;
  end

endmodule
